>>> sv/wjd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wjd_pkg
// Shared types, codes and default sizes for the worker job dispatcher.
// ----------------------------------------------------------------------------
package wjd_pkg;

  localparam int MAX_WORKERS    = 16;
  localparam int QUEUE_DEPTH    = 32;
  localparam int JOB_ID_BITS    = 16;
  localparam int WORKER_ID_BITS = 4;
  localparam int STATUS_BITS    = 4;
  localparam int OPCODE_BITS    = 2;
  localparam int WCOUNT_BITS    = 5;
  localparam int WCOUNT_RESET   = 4;
  localparam int CFG_ADDR_BITS  = 3;
  localparam int CFG_DATA_BITS  = 32;

  // register index, taken from paddr[2]
  localparam logic REG_WORKER_COUNT = 1'b0;

  typedef enum logic [OPCODE_BITS-1:0] {
    OP_SUBMIT   = 2'd0,
    OP_FINISH   = 2'd1,
    OP_SHUTDOWN = 2'd2,
    OP_START    = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_DISPATCHED  = 4'd0,
    ST_QUEUED      = 4'd1,
    ST_REJ_STOPPED = 4'd2,
    ST_REJ_FULL    = 4'd3,
    ST_PARKED      = 4'd4,
    ST_ABORTED     = 4'd5,
    ST_DONE        = 4'd6,
    ST_STARTED     = 4'd7,
    ST_BAD         = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_ABORT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic accept;  // latch request, issue queue read
    logic exec;    // run a single-result request
    logic abort;   // emit one aborted job, step the walk
    logic done;    // emit shutdown done, tear down the pool
  } wjd_cmd_t;

  typedef struct packed {
    logic out_free;
    logic op_shut;
    logic running;
    logic rem_zero;
    logic rem_one;
  } wjd_stat_t;

endpackage

>>> sv/wjd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wjd_ctrl
// Sequencer: accepts a request, runs it, and walks the queue on shutdown.
// ----------------------------------------------------------------------------
module wjd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  wjd_pkg::wjd_stat_t  stat,
  output wjd_pkg::wjd_cmd_t   cmd
);

  wjd_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wjd_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    case (state_r)
      wjd_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = wjd_pkg::S_EXEC;
        end
      end
      wjd_pkg::S_EXEC: begin
        if (stat.op_shut && stat.running) begin
          state_nxt = stat.rem_zero ? wjd_pkg::S_DONE : wjd_pkg::S_ABORT;
        end else if (stat.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = wjd_pkg::S_IDLE;
        end
      end
      wjd_pkg::S_ABORT: begin
        if (stat.out_free) begin
          cmd.abort = 1'b1;
          if (stat.rem_one) begin
            state_nxt = wjd_pkg::S_DONE;
          end
        end
      end
      wjd_pkg::S_DONE: begin
        if (stat.out_free) begin
          cmd.done  = 1'b1;
          state_nxt = wjd_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = wjd_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> sv/wjd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wjd_dp
// Datapath: job queue memory, free worker stack, busy mask, config register
// and the result register.
// ----------------------------------------------------------------------------
module wjd_dp #(
  parameter int MAX_WORKERS = wjd_pkg::MAX_WORKERS,
  parameter int QUEUE_DEPTH = wjd_pkg::QUEUE_DEPTH,
  parameter int JOB_ID_BITS = wjd_pkg::JOB_ID_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  wjd_pkg::wjd_cmd_t                    cmd,
  output wjd_pkg::wjd_stat_t                   stat,
  input  wjd_pkg::opcode_t                     in_opcode,
  input  logic [JOB_ID_BITS-1:0]               in_job,
  input  logic [wjd_pkg::WORKER_ID_BITS-1:0]   in_wid,
  input  logic                                 cfg_wr,
  input  logic                                 cfg_sel,
  input  logic [wjd_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
  output logic [wjd_pkg::CFG_DATA_BITS-1:0]    cfg_rdata,
  input  logic                                 out_tready,
  output logic                                 out_valid,
  output wjd_pkg::status_t                     out_status,
  output logic [JOB_ID_BITS-1:0]               out_job,
  output logic [wjd_pkg::WORKER_ID_BITS-1:0]   out_worker,
  output logic                                 out_last
);

  localparam int WB  = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int SDW = $clog2(MAX_WORKERS + 1);
  localparam int QW  = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int WCB = wjd_pkg::WCOUNT_BITS;
  localparam int WIB = wjd_pkg::WORKER_ID_BITS;

  // configuration
  logic [WCB-1:0] wcount_r;

  // request latch
  wjd_pkg::opcode_t       op_r;
  logic [JOB_ID_BITS-1:0] job_r;
  logic [WIB-1:0]         wid_r;

  // pool state
  logic                   running_r, running_nxt;
  logic [QW-1:0]          head_r, head_nxt;
  logic [QW-1:0]          tail_r, tail_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [SDW-1:0]         sdepth_r, sdepth_nxt;
  logic [MAX_WORKERS-1:0] busy_r, busy_nxt;
  logic [WB-1:0]          stack_r [MAX_WORKERS];

  // shutdown walk
  logic [QW-1:0]          wp_r;
  logic [CW-1:0]          rem_r;

  // queue memory
  logic [JOB_ID_BITS-1:0] fifo_mem [QUEUE_DEPTH];
  logic [JOB_ID_BITS-1:0] rd_data_r;
  logic                   rd_en;
  logic [QW-1:0]          rd_addr;
  logic                   wr_en;

  // result register
  logic                   out_valid_r, out_valid_nxt;
  wjd_pkg::status_t       out_status_r, out_status_nxt;
  logic [JOB_ID_BITS-1:0] out_job_r, out_job_nxt;
  logic [WIB-1:0]         out_worker_r, out_worker_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   out_free;
  logic [QW-1:0]          tail_m1;
  logic [QW-1:0]          wp_m1;
  logic [SDW-1:0]         sd_m1;
  logic [WB-1:0]          top_w;
  logic [WB-1:0]          wid_w;
  logic                   wid_busy;
  logic [SDW-1:0]         start_n;
  logic                   do_start;
  logic                   do_push;

  assign out_free = !out_valid_r || out_tready;
  assign tail_m1  = (tail_r == '0) ? QW'(QUEUE_DEPTH - 1) : tail_r - QW'(1);
  assign wp_m1    = (wp_r == '0) ? QW'(QUEUE_DEPTH - 1) : wp_r - QW'(1);
  assign sd_m1    = sdepth_r - SDW'(1);
  assign top_w    = stack_r[WB'(sd_m1)];
  assign wid_w    = WB'(wid_r);
  assign wid_busy = (int'(wid_r) < MAX_WORKERS) && busy_r[wid_w];

  always_comb begin
    if (wcount_r == '0) begin
      start_n = SDW'(1);
    end else if (int'(wcount_r) > MAX_WORKERS) begin
      start_n = SDW'(MAX_WORKERS);
    end else begin
      start_n = SDW'(wcount_r);
    end
  end

  assign stat.out_free = out_free;
  assign stat.op_shut  = (op_r == wjd_pkg::OP_SHUTDOWN);
  assign stat.running  = running_r;
  assign stat.rem_zero = (rem_r == '0);
  assign stat.rem_one  = (rem_r == CW'(1));

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcount_r <= WCB'(wjd_pkg::WCOUNT_RESET);
    end else if (cfg_wr && cfg_sel == wjd_pkg::REG_WORKER_COUNT) begin
      wcount_r <= cfg_wdata[WCB-1:0];
    end
  end

  assign cfg_rdata = (cfg_sel == wjd_pkg::REG_WORKER_COUNT) ?
                     wjd_pkg::CFG_DATA_BITS'(wcount_r) : '0;

  // request latch and walk pointer
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_opcode;
      job_r <= in_job;
      wid_r <= in_wid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rem_r <= '0;
    end else if (cmd.accept) begin
      wp_r  <= tail_m1;
      rem_r <= count_r;
    end else if (cmd.abort) begin
      wp_r  <= wp_m1;
      rem_r <= rem_r - CW'(1);
    end
  end

  // queue memory: read newest entry for shutdown, oldest otherwise
  always_comb begin
    rd_en   = cmd.accept || cmd.abort;
    rd_addr = head_r;
    if (cmd.abort) begin
      rd_addr = wp_m1;
    end else if (in_opcode == wjd_pkg::OP_SHUTDOWN) begin
      rd_addr = tail_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fifo_mem[tail_r] <= job_r;
    end
    if (rd_en) begin
      rd_data_r <= fifo_mem[rd_addr];
    end
  end

  // free worker stack
  always_ff @(posedge clk) begin
    if (do_start) begin
      for (int i = 0; i < MAX_WORKERS; i++) begin
        stack_r[i] <= WB'(i);
      end
    end else if (do_push) begin
      stack_r[WB'(sdepth_r)] <= wid_w;
    end
  end

  // request execution
  always_comb begin
    running_nxt    = running_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    sdepth_nxt     = sdepth_r;
    busy_nxt       = busy_r;
    wr_en          = 1'b0;
    do_start       = 1'b0;
    do_push        = 1'b0;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_job_nxt    = out_job_r;
    out_worker_nxt = out_worker_r;
    out_last_nxt   = out_last_r;

    if (cmd.exec || cmd.abort || cmd.done) begin
      out_valid_nxt  = 1'b1;
      out_job_nxt    = '0;
      out_worker_nxt = '0;
      out_last_nxt   = 1'b1;
    end

    if (cmd.abort) begin
      out_status_nxt = wjd_pkg::ST_ABORTED;
      out_job_nxt    = rd_data_r;
      out_last_nxt   = 1'b0;
    end else if (cmd.done) begin
      out_status_nxt = wjd_pkg::ST_DONE;
      running_nxt    = 1'b0;
      head_nxt       = '0;
      tail_nxt       = '0;
      count_nxt      = '0;
      sdepth_nxt     = '0;
      busy_nxt       = '0;
    end else if (cmd.exec) begin
      case (op_r)
        wjd_pkg::OP_SUBMIT: begin
          out_job_nxt = job_r;
          if (!running_r) begin
            out_status_nxt = wjd_pkg::ST_REJ_STOPPED;
          end else if (sdepth_r != '0) begin
            out_status_nxt   = wjd_pkg::ST_DISPATCHED;
            out_worker_nxt   = WIB'(top_w);
            sdepth_nxt       = sd_m1;
            busy_nxt[top_w]  = 1'b1;
          end else if (count_r < CW'(QUEUE_DEPTH)) begin
            out_status_nxt = wjd_pkg::ST_QUEUED;
            wr_en          = 1'b1;
            count_nxt      = count_r + CW'(1);
            tail_nxt       = (tail_r == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + QW'(1);
          end else begin
            out_status_nxt = wjd_pkg::ST_REJ_FULL;
          end
        end
        wjd_pkg::OP_FINISH: begin
          out_worker_nxt = wid_r;
          if (!running_r || !wid_busy) begin
            out_status_nxt = wjd_pkg::ST_BAD;
          end else if (count_r != '0) begin
            out_status_nxt = wjd_pkg::ST_DISPATCHED;
            out_job_nxt    = rd_data_r;
            count_nxt      = count_r - CW'(1);
            head_nxt       = (head_r == QW'(QUEUE_DEPTH - 1)) ? '0 : head_r + QW'(1);
          end else begin
            out_status_nxt  = wjd_pkg::ST_PARKED;
            busy_nxt[wid_w] = 1'b0;
            if (int'(sdepth_r) < MAX_WORKERS) begin
              do_push    = 1'b1;
              sdepth_nxt = sdepth_r + SDW'(1);
            end
          end
        end
        wjd_pkg::OP_START: begin
          if (running_r) begin
            out_status_nxt = wjd_pkg::ST_BAD;
          end else begin
            out_status_nxt = wjd_pkg::ST_STARTED;
            do_start       = 1'b1;
            sdepth_nxt     = start_n;
            head_nxt       = '0;
            tail_nxt       = '0;
            count_nxt      = '0;
            busy_nxt       = '0;
            running_nxt    = 1'b1;
          end
        end
        default: begin
          // shutdown of a stopped pool: report done, nothing to tear down
          out_status_nxt = wjd_pkg::ST_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      sdepth_r    <= '0;
      busy_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      running_r   <= running_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      sdepth_r    <= sdepth_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_job_r    <= out_job_nxt;
    out_worker_r <= out_worker_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_job    = out_job_r;
  assign out_worker = out_worker_r;
  assign out_last   = out_last_r;

`ifndef SYNTHESIS
  a_sdepth_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(sdepth_r) <= MAX_WORKERS)
    else $error("free stack depth beyond worker limit");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= QUEUE_DEPTH)
    else $error("queue count beyond queue depth");

  a_stopped_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |-> (busy_r == '0 && count_r == '0))
    else $error("stopped pool holds busy workers or queued jobs");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec || cmd.abort || cmd.done) |-> out_free)
    else $error("result register overwritten while held");
`endif

endmodule

>>> sv/worker_job_dispatcher.sv
`timescale 1ns / 1ps
// A submit, finish or start result is registered in the execute state, which
//   waits while the result register is held. Requests are taken one at a time:
//   accept, then execute against the registered queue memory read.
// Shutdown, k queued jobs: k aborts, newest first, one per cycle unless stalled.
// Reset: synchronous, active low; pool stopped, queue and stack empty,
//   worker_count back to 4; no clearing pass.
// ----------------------------------------------------------------------------
// worker_job_dispatcher
// Hands job ids to a pool of workers through a free worker stack and a job
// queue; stream request and result channels, APB-style config port.
// ----------------------------------------------------------------------------
module worker_job_dispatcher #(
  parameter int MAX_WORKERS = wjd_pkg::MAX_WORKERS,
  parameter int QUEUE_DEPTH = wjd_pkg::QUEUE_DEPTH,
  parameter int JOB_ID_BITS = wjd_pkg::JOB_ID_BITS,
  localparam int DW = ((JOB_ID_BITS + wjd_pkg::WORKER_ID_BITS + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [DW-1:0]                       in_tdata,   // job_id, worker_id
  input  logic [wjd_pkg::OPCODE_BITS-1:0]     in_tuser,   // opcode
  // result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [DW-1:0]                       out_tdata,  // out_job, out_worker
  output logic [wjd_pkg::STATUS_BITS-1:0]     out_tuser,  // status
  output logic                                out_tlast,
  // configuration
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [wjd_pkg::CFG_ADDR_BITS-1:0]   cfg_paddr,
  input  logic [wjd_pkg::CFG_DATA_BITS-1:0]   cfg_pwdata,
  output logic [wjd_pkg::CFG_DATA_BITS-1:0]   cfg_prdata,
  output logic                                cfg_pready
);

  localparam int WIB = wjd_pkg::WORKER_ID_BITS;

  wjd_pkg::wjd_cmd_t      cmd;
  wjd_pkg::wjd_stat_t     stat;
  wjd_pkg::status_t       res_status;
  logic [JOB_ID_BITS-1:0] res_job;
  logic [WIB-1:0]         res_worker;
  logic                   cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  wjd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  wjd_dp #(
    .MAX_WORKERS (MAX_WORKERS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .JOB_ID_BITS (JOB_ID_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_opcode  (wjd_pkg::opcode_t'(in_tuser)),
    .in_job     (in_tdata[JOB_ID_BITS-1:0]),
    .in_wid     (in_tdata[JOB_ID_BITS+WIB-1:JOB_ID_BITS]),
    .cfg_wr     (cfg_wr),
    .cfg_sel    (cfg_paddr[2]),
    .cfg_wdata  (cfg_pwdata),
    .cfg_rdata  (cfg_prdata),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_status (res_status),
    .out_job    (res_job),
    .out_worker (res_worker),
    .out_last   (out_tlast)
  );

  assign out_tuser = res_status;
  assign out_tdata = DW'({res_worker, res_job});

endmodule

>>> test/tb_worker_job_dispatcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_worker_job_dispatcher
// Self-checking bench for the worker job dispatcher. Requests are pushed
// through the stream input, and a scoreboard models the free worker stack,
// the job queue and the busy mask to predict every result. Each accepted
// result is compared field by field. Both channels stall at random, and
// worker_count is reprogrammed between pool runs over its full range.
// ----------------------------------------------------------------------------
module tb_worker_job_dispatcher;
  import wjd_pkg::*;

  localparam int DW = ((JOB_ID_BITS + WORKER_ID_BITS + 7) / 8) * 8;

  class dispatch_scoreboard;
    typedef struct packed {
      status_t                   status;
      logic [JOB_ID_BITS-1:0]    job;
      logic [WORKER_ID_BITS-1:0] worker;
      logic                      last;
    } result_t;

    result_t                   pending_results[$];
    logic [WCOUNT_BITS-1:0]    worker_count;
    logic                      running;
    logic [JOB_ID_BITS-1:0]    job_fifo[QUEUE_DEPTH];
    logic [4:0]                fifo_head;
    logic [5:0]                fifo_count;
    logic [WORKER_ID_BITS-1:0] free_stack[MAX_WORKERS];
    logic [4:0]                stack_depth;
    logic [MAX_WORKERS-1:0]    busy_mask;
    int                        errors;
    int                        results_seen;
    int                        status_seen[9];

    function new();
      worker_count = WCOUNT_BITS'(WCOUNT_RESET);
      running      = 1'b0;
      fifo_head    = '0;
      fifo_count   = '0;
      stack_depth  = '0;
      busy_mask    = '0;
      errors       = 0;
      results_seen = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("ERROR @%0t: %s", $time, msg);
    endtask

    function void push(status_t st, logic [JOB_ID_BITS-1:0] job,
                       logic [WORKER_ID_BITS-1:0] wk, logic last);
      result_t r;
      r = '{st, job, wk, last};
      pending_results.insert(pending_results.size(), r);
    endfunction

    // Advance the pool model by one accepted request and queue its results.
    function void note_request(opcode_t op, logic [JOB_ID_BITS-1:0] job,
                               logic [WORKER_ID_BITS-1:0] wid);
      int n;
      logic [WORKER_ID_BITS-1:0] w;
      case (op)
        OP_START: begin
          if (running) begin
            push(ST_BAD, '0, '0, 1'b1);
          end else begin
            n = int'(worker_count);
            if (n < 1) n = 1;
            if (n > MAX_WORKERS) n = MAX_WORKERS;
            for (int i = 0; i < n; i++) free_stack[i] = i[WORKER_ID_BITS-1:0];
            stack_depth = n[4:0];
            fifo_head   = '0;
            fifo_count  = '0;
            busy_mask   = '0;
            running     = 1'b1;
            push(ST_STARTED, '0, '0, 1'b1);
          end
        end
        OP_SUBMIT: begin
          if (!running) begin
            push(ST_REJ_STOPPED, job, '0, 1'b1);
          end else if (stack_depth > 0) begin
            stack_depth--;
            w = free_stack[stack_depth[WORKER_ID_BITS-1:0]];
            busy_mask[w] = 1'b1;
            push(ST_DISPATCHED, job, w, 1'b1);
          end else if (fifo_count < QUEUE_DEPTH) begin
            job_fifo[5'((fifo_head + fifo_count) % QUEUE_DEPTH)] = job;
            fifo_count++;
            push(ST_QUEUED, job, '0, 1'b1);
          end else begin
            push(ST_REJ_FULL, job, '0, 1'b1);
          end
        end
        OP_FINISH: begin
          if (!running || !busy_mask[wid]) begin
            push(ST_BAD, '0, wid, 1'b1);
          end else if (fifo_count > 0) begin
            push(ST_DISPATCHED, job_fifo[fifo_head], wid, 1'b1);
            fifo_head = 5'((fifo_head + 1) % QUEUE_DEPTH);
            fifo_count--;
          end else begin
            busy_mask[wid] = 1'b0;
            if (stack_depth < MAX_WORKERS) begin
              free_stack[stack_depth[WORKER_ID_BITS-1:0]] = wid;
              stack_depth++;
            end
            push(ST_PARKED, '0, wid, 1'b1);
          end
        end
        default: begin
          // abort queued jobs newest first, then tear the pool down
          if (running) begin
            for (int i = int'(fifo_count); i > 0; i--)
              push(ST_ABORTED, job_fifo[5'((fifo_head + i - 1) % QUEUE_DEPTH)], '0, 1'b0);
            running     = 1'b0;
            fifo_head   = '0;
            fifo_count  = '0;
            stack_depth = '0;
            busy_mask   = '0;
          end
          push(ST_DONE, '0, '0, 1'b1);
        end
      endcase
    endfunction

    task check_result(logic [STATUS_BITS-1:0] st, logic [JOB_ID_BITS-1:0] job,
                      logic [WORKER_ID_BITS-1:0] wk, logic last);
      result_t e;
      results_seen++;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result status %0d job %h worker %0d", st, job, wk));
        return;
      end
      e = pending_results.pop_front();
      status_seen[e.status]++;
      if (st !== e.status)
        report($sformatf("status %0d, want %s", st, e.status.name()));
      if (job !== e.job)
        report($sformatf("%s: job %h, want %h", e.status.name(), job, e.job));
      if (wk !== e.worker)
        report($sformatf("%s: worker %0d, want %0d", e.status.name(), wk, e.worker));
      if (last !== e.last)
        report($sformatf("%s: last %b, want %b", e.status.name(), last, e.last));
    endtask
  endclass

  logic                     clk         = 1'b0;
  logic                     rst_n       = 1'b0;
  logic                     in_tvalid   = 1'b0;
  logic                     in_tready;
  logic [DW-1:0]            in_tdata    = '0;
  logic [OPCODE_BITS-1:0]   in_tuser    = '0;
  logic                     out_tvalid;
  logic                     out_tready  = 1'b0;
  logic [DW-1:0]            out_tdata;
  logic [STATUS_BITS-1:0]   out_tuser;
  logic                     out_tlast;
  logic                     cfg_psel    = 1'b0;
  logic                     cfg_penable = 1'b0;
  logic                     cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_BITS-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_BITS-1:0] cfg_prdata;
  logic                     cfg_pready;

  dispatch_scoreboard sb;
  bit quiet = 1'b0;
  int requests_sent = 0;
  int op_count[4] = '{0, 0, 0, 0};
  int config_writes = 0;

  worker_job_dispatcher u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),     // job_id, worker_id
    .in_tuser    (in_tuser),     // opcode
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),    // out_job, out_worker
    .out_tuser   (out_tuser),    // status
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // result side: random stall bursts, none once the run goes quiet
  initial begin : result_ready
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!quiet && stall_left == 0 && $urandom_range(0, 4) == 0)
        stall_left = $urandom_range(1, 4);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tuser, out_tdata[JOB_ID_BITS-1:0],
                      out_tdata[JOB_ID_BITS +: WORKER_ID_BITS], out_tlast);
  end

  // Leaves tvalid high after the handshake; the next call or a drain settles it.
  task automatic send_request(opcode_t op, logic [JOB_ID_BITS-1:0] job,
                              logic [WORKER_ID_BITS-1:0] wid);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= DW'({wid, job});
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, job, wid);
    requests_sent++;
    op_count[op]++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending_results.size() != 0);
  endtask

  // Write worker_count, then read it back in the following transfer.
  task automatic set_worker_count(logic [WCOUNT_BITS-1:0] wc);
    logic [CFG_DATA_BITS-1:0] rd;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_BITS'({REG_WORKER_COUNT, 2'b00});
    cfg_pwdata  <= ($urandom() << WCOUNT_BITS) | CFG_DATA_BITS'(wc);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.worker_count = wc;
    config_writes++;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (rd !== CFG_DATA_BITS'(wc))
      sb.report($sformatf("worker_count reads %h, want %h", rd, wc));
  endtask

  initial begin : stimulus
    logic [WCOUNT_BITS-1:0]    wc_plan[5];
    logic [WCOUNT_BITS-1:0]    wc;
    logic [WORKER_ID_BITS-1:0] wid;
    int random_base;
    int seq_idx;
    int n_ops;
    int sel;

    sb = new();
    wc_plan = '{5'd16, 5'd31, 5'd1, 5'd17, 5'd2};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // corner cases with the reset worker_count of four
    send_request(OP_SHUTDOWN, '0, '0);
    send_request(OP_SUBMIT, 16'hFFFF, '0);
    send_request(OP_FINISH, '0, 4'd15);
    send_request(OP_START, '0, '0);
    send_request(OP_START, '0, '0);
    send_request(OP_SUBMIT, 16'h0000, '0);
    send_request(OP_SUBMIT, 16'h8001, '0);
    send_request(OP_SUBMIT, 16'h1234, '0);
    send_request(OP_SUBMIT, 16'hFFFF, '0);
    send_request(OP_SUBMIT, 16'h0000, '0);
    send_request(OP_SUBMIT, 16'hFFFF, '0);
    send_request(OP_FINISH, '0, 4'd15);
    send_request(OP_FINISH, '0, 4'd2);
    send_request(OP_FINISH, '0, 4'd3);
    send_request(OP_FINISH, '0, 4'd1);
    send_request(OP_SUBMIT, 16'hABCD, '0);
    send_request(OP_SUBMIT, 16'h0F0F, '0);
    send_request(OP_SUBMIT, 16'hF0F0, '0);
    send_request(OP_SHUTDOWN, '0, '0);
    drain_results();

    // zero workers means one: fill the queue, wrap it, overflow it, abort it all
    set_worker_count('0);
    send_request(OP_START, '0, '0);
    repeat (QUEUE_DEPTH + 3) send_request(OP_SUBMIT, 16'($urandom()), '0);
    send_request(OP_FINISH, '0, 4'd0);
    send_request(OP_FINISH, '0, 4'd0);
    repeat (3) send_request(OP_SUBMIT, 16'($urandom()), '0);
    send_request(OP_SHUTDOWN, '0, '0);
    drain_results();

    random_base = requests_sent;
    seq_idx = 0;
    while (requests_sent - random_base < 50) begin
      if (seq_idx < 5)
        wc = wc_plan[seq_idx];
      else if ($urandom_range(0, 7) == 0)
        wc = WCOUNT_BITS'($urandom_range(0, 31));
      else
        wc = WCOUNT_BITS'($urandom_range(1, MAX_WORKERS));
      set_worker_count(wc);
      seq_idx++;
      if ($urandom_range(0, 3) == 0)
        send_request(opcode_t'($urandom_range(0, 2)), 16'($urandom()), 4'($urandom()));
      send_request(OP_START, '0, '0);
      n_ops = $urandom_range(4, 24);
      repeat (n_ops) begin
        quiet = (requests_sent - random_base) >= 30;
        sel = $urandom_range(0, 99);
        if (sel < 50) begin
          send_request(OP_SUBMIT, 16'($urandom()), 4'($urandom()));
        end else if (sel < 85) begin
          // mostly finish a worker that is actually busy
          wid = 4'($urandom());
          if (sb.busy_mask != 0 && $urandom_range(0, 3) != 0)
            while (!sb.busy_mask[wid]) wid = 4'($urandom());
          send_request(OP_FINISH, 16'($urandom()), wid);
        end else if (sel < 92) begin
          send_request(OP_START, 16'($urandom()), 4'($urandom()));
        end else begin
          drain_results();
        end
      end
      send_request(OP_SHUTDOWN, 16'($urandom()), 4'($urandom()));
      drain_results();
    end

    repeat (8) @(posedge clk);
    $display("Covered %0d requests (submit %0d, finish %0d, shutdown %0d, start %0d), %0d results",
             requests_sent, op_count[OP_SUBMIT], op_count[OP_FINISH],
             op_count[OP_SHUTDOWN], op_count[OP_START], sb.results_seen);
    $display("%0d worker_count writes, %0d jobs aborted, %0d queue-full rejections",
             config_writes, sb.status_seen[ST_ABORTED], sb.status_seen[ST_REJ_FULL]);
    if (sb.errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
